/* hw/rtl/pst_pkg.sv */
// Package with the types, codes, default entries and name helper of the port service table.
`timescale 1ns / 1ps

package pst_pkg;

	// Table geometry
	localparam int TABLE_ENTRIES = 32;
	localparam int NAME_BYTES    = 8;
	localparam int NAME_W        = 8 * NAME_BYTES;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int USED_OUT_W    = 6;

	// Operation codes
	localparam logic [1:0] OP_REGISTER = 2'd0;
	localparam logic [1:0] OP_LOOKUP   = 2'd1;
	localparam logic [1:0] OP_REMOVE   = 2'd2;
	localparam logic [1:0] OP_CLEAR    = 2'd3;

	// Protocol numbers used by the defaults
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	// Default contents loaded after reset
	localparam int DEFAULT_COUNT = 14;
	localparam int LOAD_W        = $clog2(DEFAULT_COUNT);

	localparam logic [15:0] DEF_PORT [DEFAULT_COUNT] = '{
		16'd20, 16'd21, 16'd22, 16'd23, 16'd25, 16'd53, 16'd53,
		16'd67, 16'd68, 16'd80, 16'd123, 16'd443, 16'd514, 16'd8080
	};

	localparam logic [7:0] DEF_PROTO [DEFAULT_COUNT] = '{
		PROTO_TCP, PROTO_TCP, PROTO_TCP, PROTO_TCP, PROTO_TCP, PROTO_TCP,
		PROTO_UDP, PROTO_UDP, PROTO_UDP, PROTO_TCP, PROTO_UDP, PROTO_TCP,
		PROTO_UDP, PROTO_TCP
	};

	// Names packed with the first character in the lowest byte
	localparam logic [63:0] DEF_NAME [DEFAULT_COUNT] = '{
		64'h6174_6164_2D70_7466, // ftp-data
		64'h0000_0000_0070_7466, // ftp
		64'h0000_0000_0068_7373, // ssh
		64'h0000_7465_6E6C_6574, // telnet
		64'h0000_0000_7074_6D73, // smtp
		64'h0000_0000_0073_6E64, // dns
		64'h0000_0000_0073_6E64, // dns
		64'h7672_732D_7063_6864, // dhcp-srv
		64'h696C_632D_7063_6864, // dhcp-cli
		64'h0000_0000_7074_7468, // http
		64'h0000_0000_0070_746E, // ntp
		64'h0000_0073_7074_7468, // https
		64'h0000_676F_6C73_7973, // syslog
		64'h746C_612D_7074_7468  // http-alt
	};

	// One table entry: key and stored name
	typedef struct packed {
		logic [15:0]       port;
		logic [7:0]        proto;
		logic [NAME_W-1:0] name;
	} entry_t;

	// Request from the sequencer to the table memory
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	// Finished result of one command
	typedef struct packed {
		logic                  status;
		logic                  found;
		logic [63:0]           found_name;
		logic [USED_OUT_W-1:0] entries_used;
	} result_t;

	// Keep the first NAME_BYTES bytes, zero from the first zero byte on
	function automatic logic [NAME_W-1:0] clip_name(input logic [63:0] raw);
		logic [NAME_W-1:0] res;
		logic              keep;
		res  = '0;
		keep = 1'b1;
		for (int b = 0; b < NAME_BYTES; b++) begin
			if (raw[8*b +: 8] == 8'h00) keep = 1'b0;
			if (keep) res[8*b +: 8] = raw[8*b +: 8];
		end
		return res;
	endfunction

endpackage

/* hw/rtl/pst_cmd_if.sv */
// Command channel interface of the port service table.
`timescale 1ns / 1ps

interface pst_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] port;
	logic [7:0]  proto;
	logic [63:0] service_name;

	modport source (output valid, op, port, proto, service_name, input ready);
	modport sink   (input valid, op, port, proto, service_name, output ready);
endinterface

/* hw/rtl/pst_rsp_if.sv */
// Response channel interface of the port service table.
`timescale 1ns / 1ps

interface pst_rsp_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic        found;
	logic [63:0] found_name;
	logic [5:0]  entries_used;

	modport source (output valid, status, found, found_name, entries_used, input ready);
	modport sink   (input valid, status, found, found_name, entries_used, output ready);
endinterface

/* hw/rtl/pst_table_mem.sv */
// Table memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module pst_table_mem
	import pst_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output entry_t   rd_data
);

	entry_t mem [TABLE_ENTRIES];
	entry_t rd_q;

	// Write the addressed entry
	always_ff @(posedge clk) begin
		if (req.we) mem[req.waddr] <= req.wdata;
	end

	// Register the read data
	always_ff @(posedge clk) begin
		if (req.re) rd_q <= mem[req.raddr];
	end

	assign rd_data = rd_q;

endmodule

/* hw/rtl/pst_ctrl.sv */
// Sequencer: default load, linear key search, read-modify-write of the table.
`timescale 1ns / 1ps

module pst_ctrl
	import pst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	pst_cmd_if.sink     cmd,
	output mem_req_t    mem_req,
	input  entry_t      rd_data,
	output logic        res_valid,
	output result_t     res,
	input  logic        res_take
);

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_MOVE = 3'd3;
	localparam logic [2:0] ST_RESP = 3'd4;

	logic [2:0]        state_q;
	logic [LOAD_W-1:0] load_q;
	logic [CNT_W-1:0]  used_q;
	logic [CNT_W-1:0]  idx_q;
	logic [1:0]        op_q;
	logic [15:0]       port_q;
	logic [7:0]        proto_q;
	logic [NAME_W-1:0] name_q;
	logic              pend_s1;
	logic [IDX_W-1:0]  slot_s1;
	logic [IDX_W-1:0]  slot_q;
	logic              status_q;
	logic              found_q;
	logic [63:0]       fname_q;

	logic              issue;
	logic              hit;
	logic              miss;
	logic [CNT_W-1:0]  last;

	// Search decisions on the entry read in the previous cycle
	assign issue = (idx_q < used_q);
	assign hit   = pend_s1 && (rd_data.port == port_q) && (rd_data.proto == proto_q);
	assign miss  = !hit && (idx_q == used_q);
	assign last  = used_q - CNT_W'(1);

	assign cmd.ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_RESP);

	assign res.status       = status_q;
	assign res.found        = found_q;
	assign res.found_name   = fname_q;
	assign res.entries_used = USED_OUT_W'(used_q);

	// Drive the memory ports
	always_comb begin
		mem_req = '0;
		unique case (state_q)
			ST_LOAD: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = IDX_W'(load_q);
				mem_req.wdata = '{port: DEF_PORT[load_q], proto: DEF_PROTO[load_q],
					name: clip_name(DEF_NAME[load_q])};
			end
			ST_SCAN: begin
				mem_req.re    = issue;
				mem_req.raddr = idx_q[IDX_W-1:0];
				if (hit && op_q == OP_REMOVE) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = last[IDX_W-1:0];
				end
				if (op_q == OP_REGISTER && (hit || miss)) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = hit ? slot_s1 : used_q[IDX_W-1:0];
					mem_req.wdata = '{port: port_q, proto: proto_q, name: name_q};
				end
			end
			ST_MOVE: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = slot_q;
				mem_req.wdata = rd_data;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			load_q  <= '0;
			used_q  <= CNT_W'(DEFAULT_COUNT);
			pend_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				// Write one default entry a cycle
				ST_LOAD: begin
					load_q <= load_q + LOAD_W'(1);
					if (load_q == LOAD_W'(DEFAULT_COUNT - 1)) state_q <= ST_IDLE;
				end
				// Take a command
				ST_IDLE: begin
					if (cmd.valid) begin
						idx_q   <= '0;
						pend_s1 <= 1'b0;
						unique case (cmd.op)
							OP_CLEAR: begin
								used_q  <= '0;
								state_q <= ST_RESP;
							end
							OP_REGISTER: begin
								state_q <= (used_q >= CNT_W'(TABLE_ENTRIES)) ? ST_RESP : ST_SCAN;
							end
							OP_LOOKUP: state_q <= ST_SCAN;
							OP_REMOVE: state_q <= ST_SCAN;
						endcase
					end
				end
				// Read one slot a cycle, compare the one read before
				ST_SCAN: begin
					pend_s1 <= issue;
					if (issue) begin
						idx_q   <= idx_q + CNT_W'(1);
						slot_s1 <= idx_q[IDX_W-1:0];
					end
					if (hit) begin
						state_q <= (op_q == OP_REMOVE) ? ST_MOVE : ST_RESP;
					end else if (miss) begin
						state_q <= ST_RESP;
						if (op_q == OP_REGISTER) used_q <= used_q + CNT_W'(1);
					end
				end
				// Move the last entry into the freed slot
				ST_MOVE: begin
					used_q  <= last;
					state_q <= ST_RESP;
				end
				// Hold the result until the output stage takes it
				ST_RESP: begin
					if (res_take) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Command payload and result fields
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.valid) begin
			op_q     <= cmd.op;
			port_q   <= cmd.port;
			proto_q  <= cmd.proto;
			name_q   <= clip_name(cmd.service_name);
			found_q  <= 1'b0;
			fname_q  <= '0;
			status_q <= (cmd.op == OP_REGISTER) && (used_q >= CNT_W'(TABLE_ENTRIES));
		end
		if (state_q == ST_SCAN) begin
			if (hit) begin
				slot_q <= slot_s1;
				if (op_q == OP_LOOKUP) begin
					found_q <= 1'b1;
					fname_q <= 64'(rd_data.name);
				end
			end else if (miss && op_q != OP_REGISTER) begin
				status_q <= 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/port_service_table_unit.sv */
// Top level of the port service table: sequencer, table memory and output register.
`timescale 1ns / 1ps

// Port service table: maps a (port, protocol) key to a service name of up to
// eight bytes, held in one single-port-read table memory of TABLE_ENTRIES
// entries. After reset the block loads the 14 default well-known services
// and accepts no command meanwhile. Commands are then taken one at a time:
// a clear empties the table and answers at once; register, lookup and remove
// search the table linearly, one entry per cycle through the memory read
// port, and a remove that hits then copies the last entry into the freed
// slot. A register on a full table fails at once, without a search. The
// result sits in an output register, so a new command is taken while the
// previous response still waits to be read.
module port_service_table_unit
	import pst_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	pst_cmd_if.sink cmd,
	pst_rsp_if.source rsp
);

	mem_req_t mem_req;
	entry_t   rd_data;
	logic     res_valid;
	result_t  res;
	logic     res_take;
	logic     out_valid_q;
	result_t  out_q;

	pst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.mem_req   (mem_req),
		.rd_data   (rd_data),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	pst_table_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// Load the output register when it is empty or being drained
	assign res_take = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) out_q <= res;
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_q.status;
	assign rsp.found        = out_q.found;
	assign rsp.found_name   = out_q.found_name;
	assign rsp.entries_used = out_q.entries_used;

	// Never take a command while a result is still pending in the sequencer
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ready && res_valid))
		else $error("command taken while a result is pending");

	// One command at a time: ready drops after each transaction
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("second command taken back to back");

	// A hit is always a success
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found |-> !rsp.status)
		else $error("hit reported with failure status");

	// Name is zero unless a lookup hit
	a_name_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.found |-> rsp.found_name == 64'd0)
		else $error("name returned without a hit");

endmodule

/* tb/pst_answer_checker.sv */
// Checker that mirrors the port service table and compares every response.
`timescale 1ns / 1ps

module pst_answer_checker
	import pst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	pst_cmd_if          cmd,
	pst_rsp_if          rsp,
	output int unsigned fail_count,
	output int unsigned pending
);

	localparam int SLOTS     = TABLE_ENTRIES;
	localparam int STD_COUNT = 14;

	// Well-known services loaded by the block after reset
	localparam logic [15:0] STD_PORT [STD_COUNT] = '{
		16'd20, 16'd21, 16'd22, 16'd23, 16'd25, 16'd53, 16'd53,
		16'd67, 16'd68, 16'd80, 16'd123, 16'd443, 16'd514, 16'd8080
	};
	localparam logic [7:0] STD_PROTO [STD_COUNT] = '{
		PROTO_TCP, PROTO_TCP, PROTO_TCP, PROTO_TCP, PROTO_TCP, PROTO_TCP,
		PROTO_UDP, PROTO_UDP, PROTO_UDP, PROTO_TCP, PROTO_UDP, PROTO_TCP,
		PROTO_UDP, PROTO_TCP
	};
	string std_names [STD_COUNT] = '{
		"ftp-data", "ftp", "ssh", "telnet", "smtp", "dns", "dns",
		"dhcp-srv", "dhcp-cli", "http", "ntp", "https", "syslog", "http-alt"
	};

	// Mirror of the table contents
	logic [23:0] key_mirror  [SLOTS];
	logic [63:0] name_mirror [SLOTS];
	int unsigned used_mirror;
	result_t     answer_q [$];
	result_t     want;

	// Cut a name at its first zero byte and at NAME_BYTES bytes
	function automatic logic [63:0] trim_name(input logic [63:0] raw);
		int          len;
		logic [63:0] mask;
		len = 0;
		while (len < NAME_BYTES && raw[8*len +: 8] != 8'h00)
			len++;
		mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
		return raw & mask;
	endfunction

	// Pack a string, first character in the lowest byte
	function automatic logic [63:0] pack_text(input string s);
		logic [63:0] v;
		v = '0;
		for (int i = 0; i < s.len() && i < 8; i++)
			v[8*i +: 8] = s[i];
		return v;
	endfunction

	// First slot holding the key, or the fill level on a miss
	function automatic int unsigned find_slot(input logic [23:0] key);
		for (int unsigned i = 0; i < used_mirror; i++)
			if (key_mirror[i] == key) return i;
		return used_mirror;
	endfunction

	// Apply one transaction to the mirror and work out its response
	function automatic result_t serve(input logic [1:0] op, input logic [15:0] port,
			input logic [7:0] proto, input logic [63:0] svc_name);
		result_t     ans;
		logic [23:0] key;
		int unsigned slot;
		ans  = '0;
		key  = {port, proto};
		slot = find_slot(key);
		case (op)
			OP_REGISTER: begin
				if (used_mirror >= SLOTS) begin
					ans.status = 1'b1;
				end else begin
					if (slot == used_mirror) begin
						key_mirror[slot] = key;
						used_mirror++;
					end
					name_mirror[slot] = trim_name(svc_name);
				end
			end
			OP_LOOKUP: begin
				if (slot < used_mirror) begin
					ans.found      = 1'b1;
					ans.found_name = name_mirror[slot];
				end else begin
					ans.status = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (slot < used_mirror) begin
					key_mirror[slot]  = key_mirror[used_mirror - 1];
					name_mirror[slot] = name_mirror[used_mirror - 1];
					used_mirror--;
				end else begin
					ans.status = 1'b1;
				end
			end
			default: begin
				used_mirror = 0;
			end
		endcase
		ans.entries_used = used_mirror[5:0];
		return ans;
	endfunction

	// Check responses first, then record the new command of the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				key_mirror[i]  = '0;
				name_mirror[i] = '0;
			end
			for (int i = 0; i < STD_COUNT; i++) begin
				key_mirror[i]  = {STD_PORT[i], STD_PROTO[i]};
				name_mirror[i] = trim_name(pack_text(std_names[i]));
			end
			used_mirror = STD_COUNT;
			answer_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (answer_q.size() == 0) begin
					$error("response transaction with no command outstanding");
					fail_count++;
				end else begin
					want = answer_q.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						fail_count++;
					end
					if (rsp.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp.found);
						fail_count++;
					end
					if (rsp.found_name !== want.found_name) begin
						$error("found_name: expected %h, got %h",
							want.found_name, rsp.found_name);
						fail_count++;
					end
					if (rsp.entries_used !== want.entries_used) begin
						$error("entries_used: expected %0d, got %0d",
							want.entries_used, rsp.entries_used);
						fail_count++;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				answer_q.push_back(serve(cmd.op, cmd.port, cmd.proto, cmd.service_name));
			pending = answer_q.size();
		end
	end

endmodule

/* tb/tb_top.sv */
// Testbench top: clock, reset, command stimulus and verdict for the port service table.
`timescale 1ns / 1ps

module tb_top;
	import pst_pkg::*;

	localparam int unsigned TOTAL_ITEMS = 1225;
	localparam int          POOL_SIZE   = 24;

	logic        clk;
	logic        arst_n;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned items_sent;
	int unsigned next_fill;
	int          idle_pct;
	int          stall_pct;

	// Keys reused often so that lookups and removes hit
	logic [15:0] pool_port  [POOL_SIZE];
	logic [7:0]  pool_proto [POOL_SIZE];

	pst_cmd_if cmd_ch ();
	pst_rsp_if rsp_ch ();

	port_service_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	pst_answer_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Clock: 2 ns period
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Stall the response side at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Pick the idling mix from the position in the run
	function automatic void pick_phase(input int unsigned n);
		case ((n / 80) % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 51; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 51; end
			default: begin idle_pct = 38; stall_pct = 38; end
		endcase
	endfunction

	// Random name: plain, all ones, empty, zero byte inside, or short
	function automatic logic [63:0] rand_name();
		logic [63:0] v;
		int          cut;
		v = {$urandom, $urandom};
		case ($urandom_range(5))
			0: v = '1;
			1: v = '0;
			2: begin
				cut = $urandom_range(7);
				v[8*cut +: 8] = 8'h00;
			end
			3: begin
				cut = $urandom_range(1, 7);
				v = v & ((64'd1 << (8 * cut)) - 64'd1);
			end
			default: ;
		endcase
		return v;
	endfunction

	// Draw a key: mostly from the pool, else fresh
	task automatic pick_key(output logic [15:0] port, output logic [7:0] proto);
		int r;
		r = $urandom_range(99);
		if (r < 70) begin
			r     = $urandom_range(POOL_SIZE - 1);
			port  = pool_port[r];
			proto = pool_proto[r];
		end else if (r < 85) begin
			port  = 16'($urandom);
			proto = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
		end else begin
			port  = 16'($urandom);
			proto = 8'($urandom);
		end
	endtask

	// Send one command transaction, idling first at random
	task automatic send_cmd(input logic [1:0] op, input logic [15:0] port,
			input logic [7:0] proto, input logic [63:0] svc_name);
		pick_phase(items_sent);
		while ($urandom_range(99) < idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.op           <= op;
		cmd_ch.port         <= port;
		cmd_ch.proto        <= proto;
		cmd_ch.service_name <= svc_name;
		do @(posedge clk); while (!cmd_ch.ready);
		items_sent++;
	endtask

	// Fill the table past full, then hit it with a known key
	task automatic fill_table();
		logic [15:0] fp;
		logic [7:0]  fq;
		logic [15:0] rp;
		logic [7:0]  rq;
		if ($urandom_range(1))
			send_cmd(OP_CLEAR, 16'($urandom), 8'($urandom), rand_name());
		fp = 16'($urandom);
		fq = 8'($urandom);
		send_cmd(OP_REGISTER, fp, fq, rand_name());
		repeat (33) begin
			rp = 16'($urandom);
			rq = 8'($urandom);
			send_cmd(OP_REGISTER, rp, rq, rand_name());
		end
		send_cmd(OP_REGISTER, fp, fq, rand_name());
		send_cmd(OP_LOOKUP, fp, fq, rand_name());
		send_cmd(OP_REMOVE, fp, fq, rand_name());
		send_cmd(OP_REGISTER, fp, fq, rand_name());
		send_cmd(OP_LOOKUP, fp, fq, rand_name());
	endtask

	// Stimulus
	initial begin
		logic [15:0] kp;
		logic [7:0]  kq;
		int          r;

		arst_n              <= 1'b0;
		cmd_ch.valid        <= 1'b0;
		cmd_ch.op           <= OP_LOOKUP;
		cmd_ch.port         <= '0;
		cmd_ch.proto        <= '0;
		cmd_ch.service_name <= '0;
		items_sent = 0;
		next_fill  = 100;
		idle_pct   = 0;
		stall_pct  = 0;

		pool_port[0] = 16'd20;   pool_proto[0] = PROTO_TCP;
		pool_port[1] = 16'd22;   pool_proto[1] = PROTO_TCP;
		pool_port[2] = 16'd53;   pool_proto[2] = PROTO_UDP;
		pool_port[3] = 16'd80;   pool_proto[3] = PROTO_TCP;
		pool_port[4] = 16'd443;  pool_proto[4] = PROTO_TCP;
		pool_port[5] = 16'd514;  pool_proto[5] = PROTO_UDP;
		pool_port[6] = 16'd8080; pool_proto[6] = PROTO_TCP;
		for (int i = 7; i < POOL_SIZE; i++) begin
			pool_port[i]  = 16'($urandom);
			pool_proto[i] = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: defaults, misses, overwrite, extremes, remove, clear
		send_cmd(OP_LOOKUP,   16'd20,    PROTO_TCP, '0);
		send_cmd(OP_LOOKUP,   16'd8080,  PROTO_TCP, '0);
		send_cmd(OP_LOOKUP,   16'd53,    PROTO_UDP, '0);
		send_cmd(OP_LOOKUP,   16'd53,    8'd255,    '0);
		send_cmd(OP_LOOKUP,   16'd21,    PROTO_UDP, '0);
		send_cmd(OP_REGISTER, 16'd22,    PROTO_TCP, 64'h2E7A_7978_0063_6261);
		send_cmd(OP_LOOKUP,   16'd22,    PROTO_TCP, '1);
		send_cmd(OP_REGISTER, 16'hFFFF,  8'hFF,     '1);
		send_cmd(OP_REGISTER, 16'd0,     8'd0,      '0);
		send_cmd(OP_LOOKUP,   16'hFFFF,  8'hFF,     '0);
		send_cmd(OP_LOOKUP,   16'd0,     8'd0,      '0);
		send_cmd(OP_REMOVE,   16'd23,    PROTO_TCP, '0);
		send_cmd(OP_LOOKUP,   16'd0,     8'd0,      '0);
		send_cmd(OP_REMOVE,   16'd23,    PROTO_TCP, '0);
		send_cmd(OP_REGISTER, 16'd443,   PROTO_TCP, 64'h4142_4344_4546_4700);
		send_cmd(OP_LOOKUP,   16'd443,   PROTO_TCP, '0);
		send_cmd(OP_REMOVE,   16'd20,    PROTO_TCP, '0);
		send_cmd(OP_LOOKUP,   16'd20,    PROTO_TCP, '0);
		send_cmd(OP_CLEAR,    16'd0,     8'd0,      '0);
		send_cmd(OP_LOOKUP,   16'd80,    PROTO_TCP, '0);
		send_cmd(OP_REMOVE,   16'd80,    PROTO_TCP, '0);
		send_cmd(OP_REGISTER, 16'd514,   PROTO_UDP, 64'h0067_6F6C_7379_73AA);
		send_cmd(OP_LOOKUP,   16'd514,   PROTO_UDP, '0);
		send_cmd(OP_REMOVE,   16'd514,   PROTO_UDP, '0);
		send_cmd(OP_REGISTER, 16'd8080,  PROTO_TCP, rand_name());

		// Random mix with periodic fill bursts
		while (items_sent < TOTAL_ITEMS) begin
			if (items_sent >= next_fill) begin
				fill_table();
				next_fill += 200;
			end else begin
				if ($urandom_range(99) < 3) begin
					r = $urandom_range(POOL_SIZE - 1);
					pool_port[r]  = 16'($urandom);
					pool_proto[r] = 8'($urandom);
				end
				pick_key(kp, kq);
				r = $urandom_range(99);
				if (r < 40)
					send_cmd(OP_REGISTER, kp, kq, rand_name());
				else if (r < 72)
					send_cmd(OP_LOOKUP, kp, kq, rand_name());
				else if (r < 95)
					send_cmd(OP_REMOVE, kp, kq, rand_name());
				else
					send_cmd(OP_CLEAR, kp, kq, rand_name());
			end
		end
		cmd_ch.valid <= 1'b0;

		// Drain outstanding responses, then watch for stray ones
		stall_pct = 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (50) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/pst_pkg.sv
hw/rtl/pst_cmd_if.sv
hw/rtl/pst_rsp_if.sv
hw/rtl/pst_table_mem.sv
hw/rtl/pst_ctrl.sv
hw/rtl/port_service_table_unit.sv
tb/pst_answer_checker.sv
tb/tb_top.sv
